/* rtl/lmfs_pkg.sv */
// ----------------------------------------------------------------------------
// lmfs_pkg
// Shared types, operation codes, register indexes and field widths for the
// LED matrix frame store and row scanner.
// ----------------------------------------------------------------------------
package lmfs_pkg;

	localparam int PW_W = 7;	// panel_width register
	localparam int PH_W = 6;	// panel_height register
	localparam int X_W  = 6;
	localparam int Y_W  = 5;
	localparam int RW_W = 7;
	localparam int RH_W = 6;

	localparam logic [1:0] OP_POINT = 2'd0;
	localparam logic [1:0] OP_RECT  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_SCAN  = 2'd3;

	localparam logic CFG_PANEL_WIDTH  = 1'b0;
	localparam logic CFG_PANEL_HEIGHT = 1'b1;

	// One scan read in flight: tag that travels alongside the memory read.
	typedef struct packed {
		logic       vld;
		logic       last;
		logic [3:0] row;
	} scan_tag_t;

	// Bits of one byte from pixel lo up to, not including, pixel hi (MSB first).
	function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [3:0] hi);
		return (8'hFF >> lo) & ~(8'hFF >> hi);
	endfunction

endpackage

/* rtl/lmfs_ram.sv */
// ----------------------------------------------------------------------------
// lmfs_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module lmfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

/* rtl/lmfs_seq.sv */
// ----------------------------------------------------------------------------
// lmfs_seq
// Operation sequencer: clearing sweep, byte-wise read-modify-write for
// points and rectangles, and the scan read stream.
// ----------------------------------------------------------------------------
module lmfs_seq #(
	parameter int DEPTH = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  operation,
	input  logic [lmfs_pkg::X_W-1:0]    x,
	input  logic [lmfs_pkg::Y_W-1:0]    y,
	input  logic [lmfs_pkg::RW_W-1:0]   rect_width,
	input  logic [lmfs_pkg::RH_W-1:0]   rect_height,
	input  logic                        color,
	input  logic [lmfs_pkg::PW_W-1:0]   eff_width,
	input  logic [lmfs_pkg::PH_W-1:0]   eff_height,
	output logic                        busy,
	output logic                        mem_en,
	output logic                        mem_we,
	output logic [$clog2(DEPTH)-1:0]    mem_addr,
	output logic [7:0]                  mem_wdata,
	input  logic [7:0]                  mem_rdata,
	output lmfs_pkg::scan_tag_t         tag
);
	import lmfs_pkg::*;

	localparam int AW = $clog2(DEPTH);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_WR   = 3'd4;
	localparam logic [2:0] ST_SCAN = 3'd5;

	logic [2:0]      state_q;
	logic [1:0]      op_q;
	logic [X_W-1:0]  x_q;
	logic [Y_W-1:0]  y_q;
	logic [RW_W-1:0] rw_q;
	logic [RH_W-1:0] rh_q;
	logic            color_q;
	logic [AW-1:0]   clr_addr_q;
	logic [3:0]      k_q, kfirst_q, klast_q;
	logic [2:0]      lo_q;
	logic [3:0]      hi_q;
	logic [5:0]      j_q, ye_q;
	logic [AW-1:0]   row_base_q;
	logic [3:0]      scan_row_q;
	logic [3:0]      b_q;
	logic [1:0]      band_q;
	logic [AW-1:0]   band_base_q;

	logic [3:0] bpr;
	logic [1:0] bands;
	logic [7:0] xe_raw, xe;
	logic [6:0] ye_raw, ye;
	logic [6:0] xl;
	logic       rect_empty;
	logic [8:0] y_prod;
	logic [7:0] row_prod;
	logic       scan_last;
	logic [7:0] wmask;
	logic [AW-1:0] rect_addr;

	assign bpr   = eff_width[6:3];
	assign bands = eff_height[5:4];

	// Clip the rectangle to the panel.
	assign xe_raw = {2'b0, x_q} + {1'b0, rw_q};
	assign xe     = (xe_raw > {1'b0, eff_width}) ? {1'b0, eff_width} : xe_raw;
	assign ye_raw = {2'b0, y_q} + {1'b0, rh_q};
	assign ye     = (ye_raw > {1'b0, eff_height}) ? {1'b0, eff_height} : ye_raw;
	assign rect_empty = ({2'b0, x_q} >= xe) || ({2'b0, y_q} >= ye);
	assign xl     = xe[6:0] - 7'd1;

	assign y_prod   = {4'b0, y_q} * {5'b0, bpr};
	assign row_prod = {4'b0, scan_row_q} * {4'b0, bpr};

	assign scan_last = (b_q == bpr - 4'd1) && (band_q == bands - 2'd1);
	assign wmask = span_mask((k_q == kfirst_q) ? lo_q : 3'd0,
		(k_q == klast_q) ? hi_q : 4'd8);
	assign rect_addr = row_base_q + AW'(k_q);

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = rect_addr;
		mem_wdata = 8'h00;
		tag       = '0;
		case (state_q)
			ST_CLR: begin
				mem_en   = 1'b1;
				mem_we   = 1'b1;
				mem_addr = clr_addr_q;
			end
			ST_RD: begin
				mem_en = 1'b1;
			end
			ST_WR: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_wdata = color_q ? (mem_rdata | wmask) : (mem_rdata & ~wmask);
			end
			ST_SCAN: begin
				mem_en   = 1'b1;
				mem_addr = band_base_q + AW'(b_q);
				tag.vld  = 1'b1;
				tag.last = scan_last;
				tag.row  = scan_row_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_addr_q <= '0;
			scan_row_q <= 4'd0;
		end else begin
			case (state_q)
				ST_CLR: begin
					if (clr_addr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
					clr_addr_q <= clr_addr_q + AW'(1);
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					case (op_q)
						OP_CLEAR: begin
							clr_addr_q <= '0;
							state_q    <= ST_CLR;
						end
						OP_SCAN: begin
							if (bpr == 4'd0 || bands == 2'd0) begin
								scan_row_q <= scan_row_q + 4'd1;
								state_q    <= ST_IDLE;
							end else begin
								state_q <= ST_SCAN;
							end
						end
						default: begin
							state_q <= rect_empty ? ST_IDLE : ST_RD;
						end
					endcase
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (k_q == klast_q && j_q + 6'd1 == ye_q) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						scan_row_q <= scan_row_q + 4'd1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operation fields and walk counters; no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q    <= operation;
			x_q     <= x;
			y_q     <= y;
			rw_q    <= (operation == OP_POINT) ? 7'd1 : rect_width;
			rh_q    <= (operation == OP_POINT) ? 6'd1 : rect_height;
			color_q <= color;
		end
		if (state_q == ST_PREP) begin
			k_q         <= {1'b0, x_q[5:3]};
			kfirst_q    <= {1'b0, x_q[5:3]};
			klast_q     <= xl[6:3];
			lo_q        <= x_q[2:0];
			hi_q        <= {1'b0, xl[2:0]} + 4'd1;
			j_q         <= {1'b0, y_q};
			ye_q        <= ye[5:0];
			row_base_q  <= AW'(y_prod);
			band_base_q <= AW'(row_prod);
			b_q         <= 4'd0;
			band_q      <= 2'd0;
		end
		if (state_q == ST_WR) begin
			// advance to the next byte, or wrap to the next pixel row
			if (k_q == klast_q) begin
				k_q        <= kfirst_q;
				j_q        <= j_q + 6'd1;
				row_base_q <= row_base_q + AW'(bpr);
			end else begin
				k_q <= k_q + 4'd1;
			end
		end
		if (state_q == ST_SCAN) begin
			if (b_q == bpr - 4'd1) begin
				b_q         <= 4'd0;
				band_q      <= band_q + 2'd1;
				band_base_q <= band_base_q + AW'({bpr, 4'b0});
			end else begin
				b_q <= b_q + 4'd1;
			end
		end
	end

endmodule

/* rtl/led_matrix_frame_store_and_row_scan.sv */
// A scan tick's bytes pass through the store's registered read and the output
// register, then follow one per cycle with no stall. A point or rectangle takes
// one read-modify-write of the single memory port per touched byte, and a clear
// sweeps the whole store. After reset a clearing pass over the whole store runs
// with busy high; results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// led_matrix_frame_store_and_row_scan
// 1-bit frame store for a 1/16-multiplexed LED panel with point write,
// rectangle fill, clear and row scan operations.
// ----------------------------------------------------------------------------
module led_matrix_frame_store_and_row_scan #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write port
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [lmfs_pkg::PW_W-1:0] cfg_data,
	// command
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                operation,
	input  logic [lmfs_pkg::X_W-1:0]  x,
	input  logic [lmfs_pkg::Y_W-1:0]  y,
	input  logic [lmfs_pkg::RW_W-1:0] rect_width,
	input  logic [lmfs_pkg::RH_W-1:0] rect_height,
	input  logic                      color,
	// results
	output logic                      strobe,
	output logic [7:0]                serial_byte,
	output logic [3:0]                row_address,
	output logic                      last
);
	import lmfs_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT / 8;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [PW_W-1:0] MAXW_CLIP =
		(MAX_WIDTH > 127) ? 7'd127 : PW_W'(MAX_WIDTH);
	localparam logic [PH_W-1:0] MAXH_CLIP =
		(MAX_HEIGHT > 63) ? 6'd63 : PH_W'(MAX_HEIGHT);

	logic [PW_W-1:0] width_q;
	logic [PH_W-1:0] height_q;
	logic [PW_W-1:0] eff_width;
	logic [PH_W-1:0] eff_height;

	logic          mem_en, mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata, mem_rdata;
	scan_tag_t     tag, tag_s1;

	logic       strobe_q, last_q;
	logic [7:0] serial_byte_q;
	logic [3:0] row_address_q;

	// Configuration registers: written any cycle the enable is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 6'd32;
		end else if (cfg_we) begin
			if (cfg_index == CFG_PANEL_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_index == CFG_PANEL_HEIGHT) begin
				height_q <= cfg_data[PH_W-1:0];
			end
		end
	end

	// Effective panel size: clip to the store, round down to whole bytes and
	// whole 16-line bands.
	always_comb begin
		eff_width  = ((width_q < MAXW_CLIP) ? width_q : MAXW_CLIP) & 7'h78;
		eff_height = ((height_q < MAXH_CLIP) ? height_q : MAXH_CLIP) & 6'h30;
	end

	lmfs_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.operation   (operation),
		.x           (x),
		.y           (y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.color       (color),
		.eff_width   (eff_width),
		.eff_height  (eff_height),
		.busy        (busy),
		.mem_en      (mem_en),
		.mem_we      (mem_we),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata),
		.tag         (tag)
	);

	lmfs_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Register the scan tag alongside the store's registered read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag;
		end
	end

	// Output register: invert the store byte (panel drives active low) and
	// drop the strobe when no scan read came back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= tag_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		serial_byte_q <= ~mem_rdata;
		row_address_q <= tag_s1.row;
		last_q        <= tag_s1.last;
	end

	assign strobe      = strobe_q;
	assign serial_byte = serial_byte_q;
	assign row_address = row_address_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	// A scan read never shares the port with a write.
	assert property (@(posedge clk) disable iff (!arst_n) tag.vld |-> !mem_we)
		else $error("store write during scan read");

	// The store is only written while an operation is in progress.
	assert property (@(posedge clk) disable iff (!arst_n) !busy |-> !mem_we)
		else $error("store write while idle");

	// The final byte of a scan is never followed directly by another byte.
	assert property (@(posedge clk) disable iff (!arst_n) (strobe && last) |=> !strobe)
		else $error("byte right after final scan byte");

	// Within a scan, bytes come back to back with one row address.
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> (strobe && $stable(row_address)))
		else $error("scan stream broken or row changed mid-scan");
`endif

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LED matrix frame store and row scanner. Point
// writes, rectangle fills, clears and scan ticks are sent over the command
// port. The bench keeps its own pixel map and scan row, works out the bytes
// each scan must stream, and compares every strobed byte in order. It runs
// across several panel sizes, including empty and out-of-range settings.
// ----------------------------------------------------------------------------
module tb;
	import lmfs_pkg::*;

	localparam int PANEL_MAX_W = 64;
	localparam int PANEL_MAX_H = 32;
	localparam int STORE_DEPTH = PANEL_MAX_W * PANEL_MAX_H / 8;

	// One streamed byte of a scan, as the panel shift register sees it.
	typedef struct packed {
		logic [7:0] pixels;
		logic [3:0] row;
		logic       last;
	} scan_byte_t;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             cfg_we      = 1'b0;
	logic             cfg_index   = CFG_PANEL_WIDTH;
	logic [PW_W-1:0]  cfg_data    = '0;
	logic             start       = 1'b0;
	logic             busy;
	logic [1:0]       operation   = OP_POINT;
	logic [X_W-1:0]   x           = '0;
	logic [Y_W-1:0]   y           = '0;
	logic [RW_W-1:0]  rect_width  = '0;
	logic [RH_W-1:0]  rect_height = '0;
	logic             color       = 1'b0;
	logic             strobe;
	logic [7:0]       serial_byte;
	logic [3:0]       row_address;
	logic             last;

	// Shadow of the block: pixel map, scan row and the two size registers.
	logic [7:0]       pixel_store [STORE_DEPTH];
	logic [3:0]       scan_row_shadow;
	logic [PW_W-1:0]  width_reg;
	logic [PH_W-1:0]  height_reg;

	// Bytes still owed by scans already transferred, oldest first.
	scan_byte_t       scan_bytes_due [$];
	scan_byte_t       due_byte;

	bit               gaps_on = 1'b1;
	int               error_count;
	int               bytes_checked;
	int               n_points, n_fills, n_clears, n_scans, n_sizes;

	led_matrix_frame_store_and_row_scan #(
		.MAX_WIDTH  (PANEL_MAX_W),
		.MAX_HEIGHT (PANEL_MAX_H)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.x           (x),
		.y           (y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.color       (color),
		.strobe      (strobe),
		.serial_byte (serial_byte),
		.row_address (row_address),
		.last        (last)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Shadow model
	// ------------------------------------------------------------------------

	// Usable width: clamp to the store, drop to a whole byte.
	function automatic int unsigned live_width();
		int unsigned w;
		w = (width_reg < PANEL_MAX_W) ? width_reg : PANEL_MAX_W;
		return w & ~32'd7;
	endfunction

	// Usable height: clamp to the store, drop to a whole 16-line band.
	function automatic int unsigned live_height();
		int unsigned h;
		h = (height_reg < PANEL_MAX_H) ? height_reg : PANEL_MAX_H;
		return h & ~32'd15;
	endfunction

	function automatic void set_pixel(input int unsigned px, input int unsigned py,
			input logic on, input int unsigned w, input int unsigned h);
		int unsigned idx;
		logic [7:0]  mask;
		// Drop anything off the panel.
		if (px >= w || py >= h)
			return;
		idx  = px / 8 + py * (w / 8);
		mask = 8'h80 >> (px % 8);
		if (on)
			pixel_store[idx] = pixel_store[idx] | mask;
		else
			pixel_store[idx] = pixel_store[idx] & ~mask;
	endfunction

	// Update the shadow for one transferred command and queue any scan bytes.
	function automatic void apply_command(input logic [1:0] op, input int unsigned px,
			input int unsigned py, input int unsigned rw, input int unsigned rh,
			input logic on);
		int unsigned w, h, x_end, y_end, per_row, bands, total, base, idx, n;
		scan_byte_t  sb;
		w = live_width();
		h = live_height();
		case (op)
			OP_POINT: begin
				set_pixel(px, py, on, w, h);
			end
			OP_RECT: begin
				// Clip the box to the panel; empty boxes fall out of the loops.
				x_end = (px + rw > w) ? w : px + rw;
				y_end = (py + rh > h) ? h : py + rh;
				for (int unsigned i = px; i < x_end; i++)
					for (int unsigned j = py; j < y_end; j++)
						set_pixel(i, j, on, w, h);
			end
			OP_CLEAR: begin
				// Clear hits the whole store, not just the live panel.
				foreach (pixel_store[k])
					pixel_store[k] = 8'h00;
			end
			default: begin
				// Stream the current row of every band, top band first, inverted.
				per_row = w / 8;
				bands   = h / 16;
				total   = per_row * bands;
				n       = 0;
				for (int unsigned band = 0; band < bands; band++) begin
					base = scan_row_shadow * per_row + band * per_row * 16;
					for (int unsigned b = 0; b < per_row; b++) begin
						idx       = base + b;
						sb.pixels = ~((idx < STORE_DEPTH) ? pixel_store[idx] : 8'h00);
						sb.row    = scan_row_shadow;
						sb.last   = (n + 1 == total);
						scan_bytes_due.push_back(sb);
						n++;
					end
				end
				// Advance the row even when the panel is empty.
				scan_row_shadow = scan_row_shadow + 4'd1;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Result checker: the receiver cannot stall, so take every strobe.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (scan_bytes_due.size() == 0) begin
				$error("scan byte %0h row %0d last %0b with no scan byte pending",
					serial_byte, row_address, last);
				error_count++;
			end else begin
				due_byte = scan_bytes_due.pop_front();
				bytes_checked++;
				if (serial_byte !== due_byte.pixels) begin
					$error("serial_byte: expected %0h, got %0h", due_byte.pixels, serial_byte);
					error_count++;
				end
				if (row_address !== due_byte.row) begin
					$error("row_address: expected %0d, got %0d", due_byte.row, row_address);
					error_count++;
				end
				if (last !== due_byte.last) begin
					$error("last: expected %0b, got %0b", due_byte.last, last);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Shared driving tasks
	// ------------------------------------------------------------------------

	// Transfer one command. Start is left high on return; the next call either
	// reuses it back to back or drops it, always in the same time step.
	task automatic send_cmd(input logic [1:0] op, input logic [X_W-1:0] px,
			input logic [Y_W-1:0] py, input logic [RW_W-1:0] rw,
			input logic [RH_W-1:0] rh, input logic on);
		int unsigned gap;
		gap = 0;
		if (gaps_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 16);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		operation   <= op;
		x           <= px;
		y           <= py;
		rect_width  <= rw;
		rect_height <= rh;
		color       <= on;
		// Hold the command until an edge sees busy low.
		@(posedge clk);
		while (busy)
			@(posedge clk);
		apply_command(op, px, py, rw, rh, on);
		case (op)
			OP_POINT: n_points++;
			OP_RECT:  n_fills++;
			OP_CLEAR: n_clears++;
			default:  n_scans++;
		endcase
	endtask

	// Drop start and hold off until every owed scan byte has come back.
	task automatic pause_for_results();
		start <= 1'b0;
		@(posedge clk);
		while (scan_bytes_due.size() != 0)
			@(posedge clk);
	endtask

	// Wait for the block to go fully idle, then let the pipeline drain.
	task automatic settle();
		pause_for_results();
		while (busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [PW_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == CFG_PANEL_WIDTH)
			width_reg = data;
		else
			height_reg = data[PH_W-1:0];
		@(posedge clk);
	endtask

	task automatic set_panel(input logic [PW_W-1:0] w, input logic [PW_W-1:0] h);
		settle();
		write_reg(CFG_PANEL_WIDTH, w);
		write_reg(CFG_PANEL_HEIGHT, h);
		n_sizes++;
	endtask

	// Random commands with random content; coordinates lean toward the live
	// panel so small sizes still light pixels, but strays stay in the mix.
	task automatic run_random(input int count);
		logic [1:0]      op;
		logic [X_W-1:0]  px;
		logic [Y_W-1:0]  py;
		logic [RW_W-1:0] rw;
		logic [RH_W-1:0] rh;
		int unsigned     pick, w, h;
		repeat (count) begin
			w    = live_width();
			h    = live_height();
			pick = $urandom_range(0, 99);
			if (pick < 35)
				op = OP_POINT;
			else if (pick < 55)
				op = OP_RECT;
			else if (pick < 60)
				op = OP_CLEAR;
			else
				op = OP_SCAN;
			px = X_W'($urandom_range(0, 63));
			py = Y_W'($urandom_range(0, 31));
			if (w != 0 && $urandom_range(0, 3) != 0)
				px = X_W'($urandom_range(0, w - 1));
			if (h != 0 && $urandom_range(0, 3) != 0)
				py = Y_W'($urandom_range(0, h - 1));
			// Mostly small boxes; now and then one that runs far off the panel.
			if ($urandom_range(0, 7) == 0) begin
				rw = RW_W'($urandom_range(0, 127));
				rh = RH_W'($urandom_range(0, 63));
			end else begin
				rw = RW_W'($urandom_range(0, 16));
				rh = RH_W'($urandom_range(0, 8));
			end
			send_cmd(op, px, py, rw, rh, 1'($urandom_range(0, 1)));
			if (gaps_on && $urandom_range(0, 29) == 0)
				pause_for_results();
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Points at the panel corners, a set then a darken of the same pixel,
	// framed by scans on the reset-size panel.
	task automatic test_directed_points();
		send_cmd(OP_SCAN, 0, 0, 0, 0, 1'b0);
		send_cmd(OP_POINT, 0, 0, 0, 0, 1'b1);
		send_cmd(OP_POINT, 63, 31, 127, 63, 1'b1);
		send_cmd(OP_POINT, 63, 0, 0, 0, 1'b1);
		send_cmd(OP_POINT, 0, 31, 0, 0, 1'b1);
		send_cmd(OP_POINT, 5, 17, 0, 0, 1'b1);
		send_cmd(OP_POINT, 5, 17, 0, 0, 1'b0);
		send_cmd(OP_SCAN, 63, 31, 127, 63, 1'b1);
	endtask

	// Empty boxes, a box clipped at the far corner, a full-panel fill, a dark
	// patch inside it, and a clear that wipes everything.
	task automatic test_directed_fill_clear();
		send_cmd(OP_RECT, 2, 3, 0, 5, 1'b1);
		send_cmd(OP_RECT, 2, 3, 5, 0, 1'b1);
		send_cmd(OP_RECT, 60, 28, 127, 63, 1'b1);
		send_cmd(OP_SCAN, 0, 0, 0, 0, 1'b0);
		send_cmd(OP_RECT, 0, 0, 64, 32, 1'b1);
		send_cmd(OP_RECT, 8, 4, 16, 8, 1'b0);
		send_cmd(OP_SCAN, 0, 0, 0, 0, 1'b0);
		send_cmd(OP_SCAN, 0, 0, 0, 0, 1'b0);
		send_cmd(OP_CLEAR, 0, 0, 0, 0, 1'b0);
		send_cmd(OP_SCAN, 0, 0, 0, 0, 1'b0);
	endtask

	// Walk through panel sizes: smallest, oversize settings that clamp,
	// zero width, zero height, and sizes that round down.
	task automatic test_panel_sizes();
		set_panel(7'd8, 7'd16);
		run_random(35);
		set_panel(7'd127, 7'd96);	// height keeps only its low six bits
		run_random(30);
		set_panel(7'd7, 7'd32);		// zero usable width: scans stream nothing
		run_random(12);
		set_panel(7'd64, 7'd15);	// zero usable height
		run_random(12);
		set_panel(7'd13, 7'd20);
		run_random(25);
		set_panel(7'd40, 7'd47);
		run_random(30);
		set_panel(7'd24, 7'd16);
		run_random(25);
	endtask

	// Full-size panel with commands back to back.
	task automatic test_full_rate();
		set_panel(7'd64, 7'd32);
		gaps_on = 1'b0;
		run_random(60);
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		foreach (pixel_store[k])
			pixel_store[k] = 8'h00;
		scan_row_shadow = 4'd0;
		width_reg       = 7'd64;
		height_reg      = 6'd32;

		// Hold reset, then release it; the block then runs its clearing pass
		// with busy high, which the first transfer simply waits out.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_points();
		test_directed_fill_clear();
		test_panel_sizes();
		test_full_rate();
		settle();

		$display("ran %0d point writes, %0d fills, %0d clears, %0d scans over %0d panel sizes",
			n_points, n_fills, n_clears, n_scans, n_sizes);
		$display("checked %0d streamed scan bytes", bytes_checked);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#6000000;
		$display("simulation failed");
		$finish;
	end

endmodule
